/* rtl/core/sha1_pkg.sv */
// Shared types, constants and round functions for the SHA-1 stream hasher.
`default_nettype none

package sha1_pkg;

    // Geometry of one message block and of the digest.
    localparam int BLOCK_BYTES  = 64;
    localparam int FILL_W       = 6;
    localparam int WIN_WORDS    = 16;
    localparam int ROUNDS       = 80;
    localparam int ROUND_W      = 7;
    localparam int DIGEST_WORDS = 5;
    localparam int WORD_IDX_W   = 3;
    localparam int COUNT_W      = 61;
    localparam int LEN_IDX_W    = 3;

    localparam logic [ROUND_W-1:0]    LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [FILL_W-1:0]     LAST_FILL  = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0]     LEN_OFFSET = 6'd56;
    localparam logic [WORD_IDX_W-1:0] LAST_WORD  = WORD_IDX_W'(DIGEST_WORDS - 1);
    localparam logic [LEN_IDX_W-1:0]  LAST_LEN   = 3'd7;
    localparam logic [7:0]            PAD_MARK   = 8'h80;

    // Initial chaining value.
    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } state_t;

    // Steps of the padding sequence.
    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } pad_phase_t;

    // Controls for the message window and schedule.
    typedef struct packed {
        logic              wr_en;
        logic [FILL_W-1:0] wr_addr;
        logic [7:0]        wr_byte;
        logic              shift;
    } sched_ctrl_t;

    // Controls for the shared round unit.
    typedef struct packed {
        logic                  load;
        logic                  step;
        logic                  update;
        logic                  clear;
        logic [ROUND_W-1:0]    idx;
        logic [WORD_IDX_W-1:0] word_sel;
    } round_ctrl_t;

    // Boolean function of one round.
    function automatic logic [31:0] sha1_f(input logic [ROUND_W-1:0] t,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            r = b ^ c ^ d;
        end else if (t < 7'd60) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    // Additive constant of one round.
    function automatic logic [31:0] sha1_k(input logic [ROUND_W-1:0] t);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = K0;
        end else if (t < 7'd40) begin
            r = K1;
        end else if (t < 7'd60) begin
            r = K2;
        end else begin
            r = K3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sha1_sched.sv */
// Message window: collects block bytes, then shifts out the message schedule.
`default_nettype none

module sha1_sched (
    input  wire                   clk,
    input  sha1_pkg::sched_ctrl_t ctrl,
    output logic [31:0]           w_cur
);
    import sha1_pkg::*;

    logic [31:0] win_reg [WIN_WORDS];
    logic [31:0] w_next;

    // Next schedule word W[t+16] from the window holding W[t..t+15].
    always_comb
    begin
        w_next = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_next = {w_next[30:0], w_next[31]};
    end

    assign w_cur = win_reg[0];

    // Byte writes fill the block big-endian; each round shifts the window down.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift) begin
            for (int i = 0; i < WIN_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WIN_WORDS - 1] <= w_next;
        end else if (ctrl.wr_en) begin
            win_reg[ctrl.wr_addr[FILL_W-1:2]][{~ctrl.wr_addr[1:0], 3'b000} +: 8]
                <= ctrl.wr_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sha1_round.sv */
// Shared round unit with working variables and the chaining value.
`default_nettype none

module sha1_round (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sha1_pkg::round_ctrl_t ctrl,
    input  wire [31:0]            w_cur,
    output logic [31:0]           digest_word
);
    import sha1_pkg::*;

    logic [31:0] h_reg [DIGEST_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] t_next;

    // One compression round.
    always_comb
    begin
        t_next = {a_reg[26:0], a_reg[31:27]} + sha1_f(ctrl.idx, b_reg, c_reg, d_reg)
               + e_reg + sha1_k(ctrl.idx) + w_cur;
    end

    // Working variables load from the chaining value and advance each round.
    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (ctrl.step) begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining value: add the block result, or restart after the digest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                h_reg[i] <= H_INIT[i];
            end
        end else if (ctrl.clear) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                h_reg[i] <= H_INIT[i];
            end
        end else if (ctrl.update) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    // Digest word selection for the output channel.
    always_comb
    begin
        case (ctrl.word_sel)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            default: digest_word = h_reg[4];
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/sha1_ctrl.sv */
// Sequencer: byte intake, block fill, padding, rounds and digest readout.
`default_nettype none

module sha1_ctrl (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire [7:0]                          data_byte,
    input  wire                                byte_valid,
    input  wire                                last_byte,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [sha1_pkg::WORD_IDX_W-1:0]    word_index,
    output sha1_pkg::sched_ctrl_t              sched_ctrl,
    output sha1_pkg::round_ctrl_t              round_ctrl
);
    import sha1_pkg::*;

    state_t                state_reg, state_next;
    pad_phase_t            phase_reg, phase_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [ROUND_W-1:0]    round_reg, round_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic [LEN_IDX_W-1:0]  len_reg, len_next;
    logic                  padding_reg, padding_next;

    logic       in_fire;
    logic       out_fire;
    logic       finish;
    logic       push;
    logic [7:0] push_byte;
    logic       fill_full;
    logic [63:0] bit_len;
    logic [5:0]  len_shift;
    logic [7:0]  len_byte;

    // Length field bytes, most significant first.
    always_comb
    begin
        bit_len   = {count_reg, 3'b000};
        len_shift = {3'(LAST_LEN - len_reg), 3'b000};
        len_byte  = 8'(bit_len >> len_shift);
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        push      = 1'b0;
        push_byte = data_byte;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                push     = in_valid & byte_valid;
            end
            ST_PAD:
            begin
                case (phase_reg)
                    PH_MARK:
                    begin
                        push      = 1'b1;
                        push_byte = PAD_MARK;
                    end
                    PH_ZERO:
                    begin
                        push      = (fill_reg != LEN_OFFSET);
                        push_byte = 8'h00;
                    end
                    PH_LEN:
                    begin
                        push      = 1'b1;
                        push_byte = len_byte;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        in_fire   = in_valid & in_ready;
        out_fire  = out_valid & out_ready;
        finish    = out_fire & (word_reg == LAST_WORD);
        fill_full = push & (fill_reg == LAST_FILL);

        sched_ctrl.wr_en   = push;
        sched_ctrl.wr_addr = fill_reg;
        sched_ctrl.wr_byte = push_byte;
        sched_ctrl.shift   = (state_reg == ST_ROUND);

        round_ctrl.load     = fill_full;
        round_ctrl.step     = (state_reg == ST_ROUND);
        round_ctrl.update   = (state_reg == ST_UPDATE);
        round_ctrl.clear    = finish;
        round_ctrl.idx      = round_reg;
        round_ctrl.word_sel = word_reg;
    end

    assign word_index = word_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    if (fill_full) begin
                        state_next = ST_ROUND;
                    end else if (last_byte) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!padding_reg) begin
                    state_next = ST_IDLE;
                end else if (phase_reg == PH_DONE) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_full) begin
                    state_next = ST_ROUND;
                end else if (phase_reg == PH_DONE) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Counters, padding progress and message length.
    always_comb
    begin
        fill_next    = fill_reg;
        count_next   = count_reg;
        round_next   = round_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        phase_next   = phase_reg;
        padding_next = padding_reg;

        if (push) begin
            fill_next = fill_full ? '0 : fill_reg + 1'b1;
        end
        if (in_fire && byte_valid) begin
            count_next = count_reg + 1'b1;
        end
        if (in_fire && last_byte) begin
            padding_next = 1'b1;
            phase_next   = PH_MARK;
            len_next     = '0;
        end
        if (state_reg == ST_ROUND) begin
            round_next = (round_reg == LAST_ROUND) ? '0 : round_reg + 1'b1;
        end
        if (state_reg == ST_PAD) begin
            case (phase_reg)
                PH_MARK:
                begin
                    phase_next = PH_ZERO;
                end
                PH_ZERO:
                begin
                    if (fill_reg == LEN_OFFSET) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    len_next = len_reg + 1'b1;
                    if (len_reg == LAST_LEN) begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        if (out_fire) begin
            word_next = word_reg + 1'b1;
        end
        if (finish) begin
            word_next    = '0;
            count_next   = '0;
            fill_next    = '0;
            padding_next = 1'b0;
            phase_next   = PH_MARK;
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_MARK;
            fill_reg    <= '0;
            count_reg   <= '0;
            round_reg   <= '0;
            word_reg    <= '0;
            len_reg     <= '0;
            padding_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            round_reg   <= round_next;
            word_reg    <= word_next;
            len_reg     <= len_next;
            padding_reg <= padding_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sha1_hash_stream_unit.sv */
// SHA-1 over a byte stream: input channel of bytes, output channel of digest words.
//
// The slave channel takes one transaction per message byte; tuser marks whether
// tdata carries a byte, tlast ends the message. An empty transaction with tlast
// ends the message without adding a byte.
// The slave channel takes one transaction per cycle until one completes a 64-byte
// block or carries tlast. The one that completes a block starts 80 rounds of the
// shared round unit, one round a cycle, then an update state folds the result into
// the chaining value; s_axis_tready stays low through the rounds and the update.
// After tlast the sequencer writes the padding bytes into the block buffer (up
// to 72 bytes, one or two more compressions), then offers the five digest words
// H0..H4 on the master channel, tlast on the fifth.
// The master channel holds each word until it is taken; a stalled receiver
// simply holds the block in its readout state. After the fifth word the state
// returns to the initial chaining value and input is accepted again.
// Reset returns the chaining value, counts and sequencer to their initial
// state at once; the block is ready as soon as reset is released.
`default_nettype none

module sha1_hash_stream_unit (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire        s_axis_tuser,   // [0] byte_valid
    input  wire        s_axis_tlast,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
    output logic       m_axis_tlast
);
    import sha1_pkg::*;

    sched_ctrl_t           sched_ctrl;
    round_ctrl_t           round_ctrl;
    logic [31:0]           w_cur;
    logic [31:0]           digest_word;
    logic [WORD_IDX_W-1:0] word_index;

    // Sequencer.
    sha1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .data_byte  (s_axis_tdata),
        .byte_valid (s_axis_tuser),
        .last_byte  (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .word_index (word_index),
        .sched_ctrl (sched_ctrl),
        .round_ctrl (round_ctrl)
    );

    // Block buffer and message schedule.
    sha1_sched u_sched (
        .clk   (clk),
        .ctrl  (sched_ctrl),
        .w_cur (w_cur)
    );

    // Round unit and chaining value.
    sha1_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (round_ctrl),
        .w_cur       (w_cur),
        .digest_word (digest_word)
    );

    // Output transaction payload.
    assign m_axis_tdata = {5'b00000, word_index, digest_word};
    assign m_axis_tlast = (word_index == LAST_WORD);

endmodule

`default_nettype wire

/* rtl/core/sha1_checker.sv */
// Port-level checks on the SHA-1 stream hasher, bound to the top level.
`default_nettype none

module sha1_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        m_axis_tlast
);

    // The end-of-digest mark sits on the fifth word and only there.
    a_last_on_fifth: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd4)))
        else $error("tlast does not match the fifth digest word");

    // No input is taken while the digest is being read out.
    a_busy_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while digest words are pending");

    // Digest words follow one another without a gap, in order.
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
        else $error("digest word sequence broken");

    // After the final word the block is ready for a new message.
    a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (s_axis_tready && !m_axis_tvalid))
        else $error("block not idle after the digest");

    // A stalled output transaction holds its word.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled digest word changed");

endmodule

bind sha1_hash_stream_unit sha1_checker u_sha1_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
